>>> sv/pid_position_controller_slew_limit_macros.svh
// assertion macros for the pid position controller with slew limit
// used by the top level only; empty bodies when SYNTHESIS is defined
`ifndef PID_POSITION_CONTROLLER_SLEW_LIMIT_MACROS_SVH
`define PID_POSITION_CONTROLLER_SLEW_LIMIT_MACROS_SVH
`ifndef SYNTHESIS
`define PIDSL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pidsl assertion failed");
`define PIDSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pidsl assertion failed");
`else
`define PIDSL_ASSERT_NOW(label, clk, rst, ante, cons)
`define PIDSL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> sv/pidsl_pkg.sv
// shared widths, constants, control word types and microcode rom
// for the pid position controller; no dependencies
`default_nettype none
package pidsl_pkg;

  localparam int PosW     = 19;
  localparam int ErrW     = 20;
  localparam int DerW     = 21;
  localparam int IntW     = 32;
  localparam int GainW    = 32;
  localparam int BandW    = 19;
  localparam int SlewW    = 16;
  localparam int DgW      = 4;
  localparam int PowW     = 17;
  localparam int DriveW   = 21;
  localparam int ProdW    = 64;
  localparam int TermW    = 42;
  localparam int AccW     = 43;
  localparam int SumW     = 26;
  localparam int ScaledW  = 30;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int StepW    = 3;

  localparam logic signed [ProdW-1:0]  TermLimit = 64'sd1099511627776;
  localparam logic signed [AccW-1:0]   OneQ24    = 43'sd16777216;
  localparam logic [SlewW-1:0]         SlewOff   = '1;
  localparam logic [BandW-1:0]         RateOff   = '1;
  localparam logic signed [DriveW-1:0] DriveMax  = 21'sd675840;
  localparam logic signed [ScaledW-1:0] RoundHalf = 30'sd2048;

  localparam logic [GainW-1:0] GainPReset  = 32'd19293;
  localparam logic [GainW-1:0] GainIReset  = 32'd0;
  localparam logic [GainW-1:0] GainDReset  = 32'd234881;
  localparam logic [BandW-1:0] WindowReset = 19'd100;
  localparam logic [SlewW-1:0] SlewReset   = 16'd614;
  localparam logic [DgW-1:0]   DriveReset  = 4'd11;
  localparam logic [BandW-1:0] ErrBandReset  = 19'd9;
  localparam logic [BandW-1:0] RateBandReset = 19'd9;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_P, REG_GAIN_I, REG_GAIN_D, REG_INT_WINDOW,
    REG_SLEW_LIMIT, REG_DRIVE_GAIN, REG_ERROR_BAND, REG_RATE_BAND
  } cfg_reg_t;

  typedef enum logic [1:0] {MUL_NONE, MUL_P, MUL_I, MUL_D} mul_sel_t;
  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_t;
  typedef enum logic [1:0] {PW_HOLD, PW_ROUND, PW_SLEW} pw_op_t;
  typedef enum logic {JMP_NONE, JMP_SLEW_OFF} jmp_cond_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
  } mac_ctl_t;

  typedef struct packed {
    mul_sel_t         mul_sel;
    acc_op_t          acc_op;
    pw_op_t           pw_op;
    jmp_cond_t        jmp_cond;
    logic [StepW-1:0] jmp_to;
    logic             emit;
  } uword_t;

  localparam logic [StepW-1:0] StepFirst = 3'd0;
  localparam logic [StepW-1:0] StepEmit  = 3'd6;

  function automatic uword_t ucode(input logic [StepW-1:0] step);
    uword_t w;
    w = '{mul_sel: MUL_NONE, acc_op: ACC_HOLD, pw_op: PW_HOLD,
          jmp_cond: JMP_NONE, jmp_to: StepFirst, emit: 1'b0};
    case (step)
      3'd0: w.mul_sel = MUL_P;
      3'd1: begin
        w.mul_sel = MUL_I;
        w.acc_op  = ACC_LOAD;
      end
      3'd2: begin
        w.mul_sel = MUL_D;
        w.acc_op  = ACC_ADD;
      end
      3'd3: w.acc_op = ACC_ADD;
      3'd4: begin
        w.pw_op    = PW_ROUND;
        w.jmp_cond = JMP_SLEW_OFF;
        w.jmp_to   = StepEmit;
      end
      3'd5: w.pw_op = PW_SLEW;
      3'd6: w.emit = 1'b1;
      default: w.emit = 1'b1;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

>>> sv/pidsl_if.sv
// valid/ready channels of the pid position controller
// depends on pidsl_pkg for field widths
`default_nettype none
interface pidsl_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pidsl_pkg::PosW-1:0]   measured_position;
  logic signed [pidsl_pkg::PosW-1:0]   target_position;
  logic                                start_move;
  modport source (output valid, measured_position, target_position, start_move,
                  input ready);
  modport sink (input valid, measured_position, target_position, start_move,
                output ready);
endinterface

interface pidsl_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pidsl_pkg::DriveW-1:0] drive_value;
  logic                                settled;
  modport source (output valid, drive_value, settled, input ready);
  modport sink (input valid, drive_value, settled, output ready);
endinterface
`default_nettype wire

>>> sv/pid_position_controller_slew_limit.sv
// pid position controller with slew limited power output, top level
// depends on pidsl_pkg, pidsl_if, pidsl_mac and the macros header
//
// usage: one beat on in_ch carries measured and target position in whole
// degrees and a start flag; one beat comes back on out_ch with the drive
// value (drive gain times power, Q8.12) and a settled flag.
// gains and limits sit in eight registers on the cfg_write/cfg_index/
// cfg_data port; write them only while the block is idle.
// timing: a step counter walks a seven word microcode rom, one word a
// cycle unless held at the emit step, sharing one 33x32 multiplier for
// the p, i and d terms. the result is registered when the emit step fires
// (with the slew limit off the round step jumps over the slew step), and
// the next input beat is taken once the block is idle again.
// reset restores the register defaults and clears integral, last error
// and last power. a stalled out_ch holds its beat; the next input can be
// taken and worked meanwhile, holding at the emit step until out_ch frees.
`default_nettype none
`include "pid_position_controller_slew_limit_macros.svh"
module pid_position_controller_slew_limit (
  input  logic                              clk,
  input  logic                              rst,
  pidsl_in_if.sink                          in_ch,
  pidsl_out_if.source                       out_ch,
  input  logic                              cfg_write,
  input  logic [pidsl_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [pidsl_pkg::CfgDataW-1:0]    cfg_data
);
  import pidsl_pkg::*;

  logic [GainW-1:0] gain_p, gain_i, gain_d;
  logic [BandW-1:0] integral_window, error_band, rate_band;
  logic [SlewW-1:0] slew_limit;
  logic [DgW-1:0]   drive_gain;

  logic signed [IntW-1:0] integral_sum;
  logic signed [ErrW-1:0] last_error;
  logic signed [PowW-1:0] last_power;

  logic signed [ErrW-1:0] err_q;
  logic signed [DerW-1:0] deriv_q;
  logic signed [IntW-1:0] integ_q;
  logic signed [PowW-1:0] pw;

  logic                   busy;
  logic [StepW-1:0]       step;
  logic                   out_valid;
  logic signed [DriveW-1:0] drive;
  logic                   settled;

  uword_t   uw;
  mac_ctl_t mac_ctl;
  logic signed [AccW-1:0] acc;

  logic                   accept;
  logic                   fire;
  logic                   jump;
  logic signed [ErrW-1:0] err_in;
  logic [ErrW-1:0]        err_in_abs;
  logic signed [IntW-1:0] base_int;
  logic signed [ErrW-1:0] base_err;
  logic signed [IntW:0]   int_wide;
  logic signed [IntW-1:0] int_sat;
  logic signed [IntW-1:0] integ_in;
  logic signed [DerW-1:0] deriv_in;

  logic signed [AccW-1:0]    sum_wide;
  logic signed [SumW-1:0]    sum_c;
  logic signed [ScaledW-1:0] sum_ext;
  logic signed [ScaledW-1:0] scaled;
  logic signed [PowW-1:0]    pw_round;
  logic signed [PowW:0]      lp_ext, pw_ext, slew_hi, slew_lo, pw_clamp;
  logic signed [DriveW:0]    drive_full;
  logic [ErrW-1:0]           err_abs;
  logic [DerW-1:0]           deriv_abs;
  logic                      settled_next;

  assign accept       = in_ch.valid && !busy;
  assign in_ch.ready  = !busy;
  assign out_ch.valid = out_valid;
  assign out_ch.drive_value = drive;
  assign out_ch.settled     = settled;

  assign uw   = ucode(step);
  assign fire = busy && uw.emit && (!out_valid || out_ch.ready);
  assign jump = (uw.jmp_cond == JMP_SLEW_OFF) && (slew_limit == SlewOff);
  assign mac_ctl.mul_sel = busy ? uw.mul_sel : MUL_NONE;
  assign mac_ctl.acc_op  = busy ? uw.acc_op : ACC_HOLD;

  // error, windowed integral and derivative at the input beat
  always_comb begin
    err_in     = {in_ch.target_position[PosW-1], in_ch.target_position}
               - {in_ch.measured_position[PosW-1], in_ch.measured_position};
    err_in_abs = err_in[ErrW-1] ? (~err_in + 1'b1) : err_in;
    base_int   = in_ch.start_move ? '0 : integral_sum;
    base_err   = in_ch.start_move ? '0 : last_error;
    int_wide   = {base_int[IntW-1], base_int}
               + {{(IntW+1-ErrW){err_in[ErrW-1]}}, err_in};
    if (int_wide[IntW] != int_wide[IntW-1]) begin
      int_sat = int_wide[IntW] ? {1'b1, {(IntW-1){1'b0}}} : {1'b0, {(IntW-1){1'b1}}};
    end else begin
      int_sat = int_wide[IntW-1:0];
    end
    integ_in = (err_in_abs < {1'b0, integral_window}) ? int_sat : base_int;
    deriv_in = {err_in[ErrW-1], err_in} - {base_err[ErrW-1], base_err};
  end

  // clamp to +/-1.0, scale by 11, round, slew clamp, drive gain, settled check
  always_comb begin
    if (acc > OneQ24) begin
      sum_wide = OneQ24;
    end else if (acc < -OneQ24) begin
      sum_wide = -OneQ24;
    end else begin
      sum_wide = acc;
    end
    sum_c    = sum_wide[SumW-1:0];
    sum_ext  = {{(ScaledW-SumW){sum_c[SumW-1]}}, sum_c};
    scaled   = (sum_ext <<< 3) + (sum_ext <<< 1) + sum_ext + RoundHalf;
    pw_round = scaled[PowW+11:12];
    lp_ext   = {last_power[PowW-1], last_power};
    pw_ext   = {pw[PowW-1], pw};
    slew_hi  = lp_ext + $signed({2'b00, slew_limit});
    slew_lo  = lp_ext - $signed({2'b00, slew_limit});
    if (pw_ext > slew_hi) begin
      pw_clamp = slew_hi;
    end else if (pw_ext < slew_lo) begin
      pw_clamp = slew_lo;
    end else begin
      pw_clamp = pw_ext;
    end
    drive_full = $signed({1'b0, drive_gain}) * pw;
    err_abs    = err_q[ErrW-1] ? (~err_q + 1'b1) : err_q;
    deriv_abs  = deriv_q[DerW-1] ? (~deriv_q + 1'b1) : deriv_q;
    settled_next = (err_abs <= {1'b0, error_band})
                && ((rate_band == RateOff) || (deriv_abs <= {2'b00, rate_band}));
  end

  pidsl_mac u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .gain_p (gain_p),
    .gain_i (gain_i),
    .gain_d (gain_d),
    .err    (err_q),
    .integ  (integ_q),
    .deriv  (deriv_q),
    .acc    (acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p          <= GainPReset;
      gain_i          <= GainIReset;
      gain_d          <= GainDReset;
      integral_window <= WindowReset;
      slew_limit      <= SlewReset;
      drive_gain      <= DriveReset;
      error_band      <= ErrBandReset;
      rate_band       <= RateBandReset;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_GAIN_P:     gain_p          <= cfg_data[GainW-1:0];
        REG_GAIN_I:     gain_i          <= cfg_data[GainW-1:0];
        REG_GAIN_D:     gain_d          <= cfg_data[GainW-1:0];
        REG_INT_WINDOW: integral_window <= cfg_data[BandW-1:0];
        REG_SLEW_LIMIT: slew_limit      <= cfg_data[SlewW-1:0];
        REG_DRIVE_GAIN: drive_gain      <= cfg_data[DgW-1:0];
        REG_ERROR_BAND: error_band      <= cfg_data[BandW-1:0];
        REG_RATE_BAND:  rate_band       <= cfg_data[BandW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      step         <= StepFirst;
      out_valid    <= 1'b0;
      integral_sum <= '0;
      last_error   <= '0;
      last_power   <= '0;
    end else begin
      if (accept) begin
        busy    <= 1'b1;
        step    <= StepFirst;
        err_q   <= err_in;
        integ_q <= integ_in;
        deriv_q <= deriv_in;
        if (in_ch.start_move) begin
          last_power <= '0;
        end
      end else if (busy) begin
        if (uw.emit) begin
          if (fire) begin
            busy         <= 1'b0;
            step         <= StepFirst;
            integral_sum <= integ_q;
            last_error   <= err_q;
            last_power   <= pw;
          end
        end else if (jump) begin
          step <= uw.jmp_to;
        end else begin
          step <= step + 1'b1;
        end
      end

      if (busy) begin
        case (uw.pw_op)
          PW_ROUND: pw <= pw_round;
          PW_SLEW:  pw <= pw_clamp[PowW-1:0];
          default:  pw <= pw;
        endcase
      end

      if (fire) begin
        out_valid <= 1'b1;
        drive     <= drive_full[DriveW-1:0];
        settled   <= settled_next;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `PIDSL_ASSERT_NEXT(a_accept_starts, clk, rst, accept, busy && step == StepFirst)
  `PIDSL_ASSERT_NOW(a_idle_at_first, clk, rst, !busy, step == StepFirst)
  `PIDSL_ASSERT_NEXT(a_emit_presents, clk, rst, fire, out_valid && !busy)
  `PIDSL_ASSERT_NOW(a_drive_range, clk, rst, out_valid, drive >= -DriveMax && drive <= DriveMax)
endmodule
`default_nettype wire

>>> sv/pidsl_mac.sv
// shared multiplier with term saturation and accumulator
// depends on pidsl_pkg
`default_nettype none
module pidsl_mac (
  input  logic                                clk,
  input  pidsl_pkg::mac_ctl_t                 ctl,
  input  logic [pidsl_pkg::GainW-1:0]         gain_p,
  input  logic [pidsl_pkg::GainW-1:0]         gain_i,
  input  logic [pidsl_pkg::GainW-1:0]         gain_d,
  input  logic signed [pidsl_pkg::ErrW-1:0]   err,
  input  logic signed [pidsl_pkg::IntW-1:0]   integ,
  input  logic signed [pidsl_pkg::DerW-1:0]   deriv,
  output logic signed [pidsl_pkg::AccW-1:0]   acc
);
  import pidsl_pkg::*;

  logic [GainW-1:0]                 gain;
  logic signed [IntW-1:0]           opnd;
  logic signed [ProdW:0]            prod_full;
  logic signed [ProdW-1:0]          prod;
  logic signed [ProdW-1:0]          term_wide;
  logic signed [TermW-1:0]          term;

  always_comb begin
    case (ctl.mul_sel)
      MUL_P: begin
        gain = gain_p;
        opnd = {{(IntW-ErrW){err[ErrW-1]}}, err};
      end
      MUL_I: begin
        gain = gain_i;
        opnd = integ;
      end
      MUL_D: begin
        gain = gain_d;
        opnd = {{(IntW-DerW){deriv[DerW-1]}}, deriv};
      end
      default: begin
        gain = '0;
        opnd = '0;
      end
    endcase
    prod_full = $signed({1'b0, gain}) * opnd;
  end

  always_comb begin
    if (prod > TermLimit) begin
      term_wide = TermLimit;
    end else if (prod < -TermLimit) begin
      term_wide = -TermLimit;
    end else begin
      term_wide = prod;
    end
    term = term_wide[TermW-1:0];
  end

  always_ff @(posedge clk) begin
    prod <= prod_full[ProdW-1:0];
    case (ctl.acc_op)
      ACC_LOAD: acc <= {term[TermW-1], term};
      ACC_ADD:  acc <= acc + {term[TermW-1], term};
      default:  acc <= acc;
    endcase
  end
endmodule
`default_nettype wire
